// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define QPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define QPC_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/qpc_pkg.sv
// ----------------------------------------------------------------------------
// Quad point containment package
// Widths, latencies, register codes and item types shared by the block.
// ----------------------------------------------------------------------------
package qpc_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int INNER_BITS = 63;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int CROSS_W = 2 * COORD_BITS + 3;
   localparam int SUM_W   = INNER_BITS + 2;

   localparam int MUL_LAT = 3;
   localparam int DIV_LAT = COORD_BITS + 3;
   localparam int LATENCY = 2 * DIV_LAT + 14;

   localparam logic signed [COORD_BITS-1:0] FIX_ONE = COORD_BITS'(64'd1 << FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_C1X, REG_C1Y, REG_C2X, REG_C2Y, REG_C3X, REG_C3Y, REG_C4X, REG_C4Y
   } csr_reg_type;

   localparam logic [COORD_BITS-1:0] CSR_RESET [NUM_REGS] = '{
      '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE, '0
   };

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic                         inside_res;
      logic signed [COORD_BITS-1:0] square_u;
      logic signed [COORD_BITS-1:0] square_v;
      logic                         degenerate;
   } rsp_type;

endpackage

// File: rtl/quad_point_containment.sv
// ----------------------------------------------------------------------------
// Quad point containment
// Maps a point into the unit square of a convex quadrilateral and reports
// whether it lies strictly inside.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Transfer
//  request   start, busy, req_data         start high while busy low
//  response  rsp_strobe, rsp_data          one cycle per item, no backpressure
//  csr       csr_we, csr_index, csr_wdata  write when csr_we high
//
// An item can be taken in every cycle; busy is never raised.
// The pipeline is built from two chains of bit-per-stage dividers, each
// COORD_BITS + 3 stages deep, plus the multiplier stages between them.
// Synchronous reset clears the valid chain and loads the default corners.
// ----------------------------------------------------------------------------
module quad_point_containment (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  qpc_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output qpc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [qpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qpc_pkg::COORD_BITS-1:0]      csr_wdata
);

   localparam int W   = qpc_pkg::COORD_BITS;
   localparam int F   = qpc_pkg::FRAC_BITS;
   localparam int IW  = qpc_pkg::INNER_BITS;
   localparam int DFW = qpc_pkg::DIFF_W;
   localparam int CW  = qpc_pkg::CROSS_W;
   localparam int SW  = qpc_pkg::SUM_W;
   localparam int LD  = qpc_pkg::DIV_LAT;
   localparam int LAT = qpc_pkg::LATENCY;

   logic [W-1:0] corner_ff [qpc_pkg::NUM_REGS];
   logic [LAT-1:0] vld_ff, vld_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qpc_pkg::NUM_REGS; i++) begin
            corner_ff[i] <= qpc_pkg::CSR_RESET[i];
         end
      end else if (csr_we) begin
         corner_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Differences relative to corner 1.
   logic signed [W-1:0] c1x, c1y;
   logic signed [DFW-1:0] d2x_ff, d2y_ff, d3x_ff, d3y_ff, d4x_ff, d4y_ff, dpx_ff, dpy_ff;

   assign c1x = $signed(corner_ff[qpc_pkg::REG_C1X]);
   assign c1y = $signed(corner_ff[qpc_pkg::REG_C1Y]);

   always_ff @(posedge clock) begin
      d2x_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C2X])) - DFW'(c1x);
      d2y_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C2Y])) - DFW'(c1y);
      d3x_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C3X])) - DFW'(c1x);
      d3y_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C3Y])) - DFW'(c1y);
      d4x_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C4X])) - DFW'(c1x);
      d4y_ff <= DFW'($signed(corner_ff[qpc_pkg::REG_C4Y])) - DFW'(c1y);
      dpx_ff <= DFW'(req_data.point_x) - DFW'(c1x);
      dpy_ff <= DFW'(req_data.point_y) - DFW'(c1y);
   end

   // Ten exact products for the five cross products.
   logic signed [DFW-1:0]   opa [10];
   logic signed [DFW-1:0]   opb [10];
   logic signed [2*DFW-1:0] prod [10];

   always_comb begin
      opa[0] = d4x_ff; opb[0] = d2y_ff;
      opa[1] = d4y_ff; opb[1] = d2x_ff;
      opa[2] = d4x_ff; opb[2] = d3y_ff;
      opa[3] = d4y_ff; opb[3] = d3x_ff;
      opa[4] = d3x_ff; opb[4] = d2y_ff;
      opa[5] = d3y_ff; opb[5] = d2x_ff;
      opa[6] = d4x_ff; opb[6] = dpy_ff;
      opa[7] = d4y_ff; opb[7] = dpx_ff;
      opa[8] = dpx_ff; opb[8] = d2y_ff;
      opa[9] = dpy_ff; opb[9] = d2x_ff;
   end

   generate
      for (genvar i = 0; i < 10; i++) begin : g_cross_mul
         qpc_mul #(.AW(DFW), .BW(DFW), .SH(0), .OW(2 * DFW)) u_mul (
            .clock (clock),
            .a     (opa[i]),
            .b     (opb[i]),
            .p     (prod[i])
         );
      end
   endgenerate

   // Cross products: den1, then the numerators of a0, a1, rx and ry.
   logic signed [CW-1:0] cr_ff [5];
   logic                 den1_zero;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 5; j++) begin
         cr_ff[j] <= CW'(prod[2*j]) - CW'(prod[2*j+1]);
      end
   end

   assign den1_zero = (cr_ff[0] == '0);

   logic signed [W-1:0] q1 [4];

   generate
      for (genvar i = 0; i < 4; i++) begin : g_div1
         qpc_div #(.NW(CW), .DW(CW), .QW(W), .FB(F)) u_div (
            .clock (clock),
            .num   (cr_ff[i+1]),
            .den   (cr_ff[0]),
            .quo   (q1[i])
         );
      end
   endgenerate

   // Projective stage operands.
   logic signed [W-1:0]   a0_ff, a1_ff, rx_ff, ry_ff;
   logic signed [W:0]     a0m1_ff, a1m1_ff;
   logic signed [W+1:0]   s_ff;

   always_ff @(posedge clock) begin
      a0_ff   <= q1[0];
      a1_ff   <= q1[1];
      rx_ff   <= q1[2];
      ry_ff   <= q1[3];
      a0m1_ff <= (W+1)'(q1[0]) - (W+1)'(qpc_pkg::FIX_ONE);
      a1m1_ff <= (W+1)'(q1[1]) - (W+1)'(qpc_pkg::FIX_ONE);
      s_ff    <= (W+2)'(q1[0]) + (W+2)'(q1[1]) - (W+2)'(qpc_pkg::FIX_ONE);
   end

   logic signed [IW-1:0] p01, t1, t0, nu1, nv1;

   qpc_mul #(.AW(W), .BW(W), .SH(F), .OW(IW)) u_m_a01 (
      .clock (clock), .a (a0_ff), .b (a1_ff), .p (p01)
   );
   qpc_mul #(.AW(W), .BW(W+1), .SH(F), .OW(IW)) u_m_t1 (
      .clock (clock), .a (a1_ff), .b (a1m1_ff), .p (t1)
   );
   qpc_mul #(.AW(W), .BW(W+1), .SH(F), .OW(IW)) u_m_t0 (
      .clock (clock), .a (a0_ff), .b (a0m1_ff), .p (t0)
   );
   qpc_mul #(.AW(W), .BW(W+2), .SH(F), .OW(IW)) u_m_nu1 (
      .clock (clock), .a (a1_ff), .b (s_ff), .p (nu1)
   );
   qpc_mul #(.AW(W), .BW(W+2), .SH(F), .OW(IW)) u_m_nv1 (
      .clock (clock), .a (a0_ff), .b (s_ff), .p (nv1)
   );

   logic signed [W-1:0]  rx_d, ry_d;
   logic signed [IW-1:0] p01_d;

   qpc_delay #(.WIDTH(W), .DEPTH(qpc_pkg::MUL_LAT)) u_dly_rx (
      .clock (clock), .din (rx_ff), .dout (rx_d)
   );
   qpc_delay #(.WIDTH(W), .DEPTH(qpc_pkg::MUL_LAT)) u_dly_ry (
      .clock (clock), .din (ry_ff), .dout (ry_d)
   );
   qpc_delay #(.WIDTH(IW), .DEPTH(qpc_pkg::MUL_LAT)) u_dly_p01 (
      .clock (clock), .din (p01), .dout (p01_d)
   );

   logic signed [IW-1:0] e1, e0, numu, numv;

   qpc_mul #(.AW(IW), .BW(W), .SH(F), .OW(IW)) u_m_e1 (
      .clock (clock), .a (t1), .b (rx_d), .p (e1)
   );
   qpc_mul #(.AW(IW), .BW(W), .SH(F), .OW(IW)) u_m_e0 (
      .clock (clock), .a (t0), .b (ry_d), .p (e0)
   );
   qpc_mul #(.AW(IW), .BW(W), .SH(F), .OW(IW)) u_m_nu (
      .clock (clock), .a (nu1), .b (rx_d), .p (numu)
   );
   qpc_mul #(.AW(IW), .BW(W), .SH(F), .OW(IW)) u_m_nv (
      .clock (clock), .a (nv1), .b (ry_d), .p (numv)
   );

   logic signed [SW-1:0] den2_ff;
   logic signed [IW-1:0] numu_ff, numv_ff;
   logic                 den2_zero;

   always_ff @(posedge clock) begin
      den2_ff <= SW'(p01_d) + SW'(e1) + SW'(e0);
      numu_ff <= numu;
      numv_ff <= numv;
   end

   assign den2_zero = (den2_ff == '0);

   logic signed [W-1:0] u_q, v_q;

   qpc_div #(.NW(IW), .DW(SW), .QW(W), .FB(F)) u_div_u (
      .clock (clock), .num (numu_ff), .den (den2_ff), .quo (u_q)
   );
   qpc_div #(.NW(IW), .DW(SW), .QW(W), .FB(F)) u_div_v (
      .clock (clock), .num (numv_ff), .den (den2_ff), .quo (v_q)
   );

   logic z1_d, z2_d;

   qpc_delay #(.WIDTH(1), .DEPTH(2 * LD + 8)) u_dly_z1 (
      .clock (clock), .din (den1_zero), .dout (z1_d)
   );
   qpc_delay #(.WIDTH(1), .DEPTH(LD)) u_dly_z2 (
      .clock (clock), .din (den2_zero), .dout (z2_d)
   );

   qpc_pkg::rsp_type rsp_ff, rsp_in;
   logic             degen;

   assign degen = z1_d | z2_d;

   always_comb begin
      rsp_in.degenerate = degen;
      rsp_in.square_u   = degen ? '0 : u_q;
      rsp_in.square_v   = degen ? '0 : v_q;
      rsp_in.inside_res = ~degen && (u_q > 0) && (u_q < qpc_pkg::FIX_ONE)
                          && (v_q > 0) && (v_q < qpc_pkg::FIX_ONE);
   end

   always_ff @(posedge clock) begin
      if (vld_ff[LAT-2]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = vld_ff[LAT-1];
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/qpc_delay.sv
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth shift register that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module qpc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// File: rtl/qpc_mul.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point multiplier
// Signed product in two halves, then arithmetic shift and, when OW < AW + BW, saturation.
// ----------------------------------------------------------------------------
module qpc_mul #(
   parameter int AW = 33,
   parameter int BW = 33,
   parameter int SH = 0,
   parameter int OW = 66
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [OW-1:0] p
);

   localparam int LW = AW / 2;
   localparam int HW = AW - LW;
   localparam int PW = AW + BW;

   logic signed [LW+BW:0]   pl_ff, pl_in;
   logic signed [HW+BW-1:0] ph_ff, ph_in;
   logic signed [PW-1:0]    full_ff, full_in;
   logic signed [PW-1:0]    shr;
   logic signed [OW-1:0]    p_ff, p_in;

   // The operand a is split into an unsigned low half and a signed high half.
   assign pl_in   = $signed({1'b0, a[LW-1:0]}) * b;
   assign ph_in   = $signed(a[AW-1:LW]) * b;
   assign full_in = (PW'(ph_ff) <<< LW) + PW'(pl_ff);
   assign shr     = full_ff >>> SH;

   generate
      if (OW >= PW) begin : g_wide
         assign p_in = OW'(shr);
      end else begin : g_sat
         logic [PW-OW:0] top;
         logic           fits;
         assign top  = shr[PW-1:OW-1];
         assign fits = (&top) | ~(|top);
         assign p_in = fits ? shr[OW-1:0] : {shr[PW-1], {(OW-1){~shr[PW-1]}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      pl_ff   <= pl_in;
      ph_ff   <= ph_in;
      full_ff <= full_in;
      p_ff    <= p_in;
   end

   assign p = p_ff;

endmodule

// File: rtl/qpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// num * 2^FB / den, truncated toward zero and saturated, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module qpc_div #(
   parameter int NW = 67,
   parameter int DW = 67,
   parameter int QW = 32,
   parameter int FB = 16
) (
   input  logic                 clock,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [QW-1:0] quo
);

   localparam int XA = NW + FB;
   localparam int XB = DW + QW;
   localparam int RW = ((XA > XB) ? XA : XB) + 1;

   logic [NW-1:0] mn_ff, mn_in;
   logic [DW-1:0] md_ff, md_in;
   logic          sga_ff;

   logic [RW-1:0] rem_ff [QW+1];
   logic [DW-1:0] dv_ff  [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          sg_ff  [QW+1];
   logic          ovf_ff [QW+1];

   logic [RW-1:0] rem0;
   logic [QW-1:0] lim, res;
   logic signed [QW-1:0] quo_ff, quo_in;

   assign mn_in = num[NW-1] ? (NW'(~num) + NW'(1)) : NW'(num);
   assign md_in = den[DW-1] ? (DW'(~den) + DW'(1)) : DW'(den);
   assign rem0  = RW'(mn_ff) << FB;

   always_ff @(posedge clock) begin
      mn_ff     <= mn_in;
      md_ff     <= md_in;
      sga_ff    <= num[NW-1] ^ den[DW-1];
      rem_ff[0] <= rem0;
      dv_ff[0]  <= md_ff;
      q_ff[0]   <= '0;
      sg_ff[0]  <= sga_ff;
      // A quotient of 2^QW or more can only saturate.
      ovf_ff[0] <= rem0 >= (RW'(md_ff) << QW);
   end

   generate
      for (genvar k = 0; k < QW; k++) begin : g_bit
         localparam int B = QW - 1 - k;
         logic [RW:0] trial;
         logic        ge;
         assign trial = {1'b0, rem_ff[k]} - ({1'b0, RW'(dv_ff[k])} << B);
         assign ge    = ~trial[RW];
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? trial[RW-1:0] : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (ge ? (QW'(1) << B) : QW'(0));
            dv_ff[k+1]  <= dv_ff[k];
            sg_ff[k+1]  <= sg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   endgenerate

   assign lim    = sg_ff[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
   assign res    = (ovf_ff[QW] || (q_ff[QW] > lim)) ? lim : q_ff[QW];
   assign quo_in = sg_ff[QW] ? $signed(QW'(~res) + QW'(1)) : $signed(res);

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

// File: rtl/qpc_checker.sv
// ----------------------------------------------------------------------------
// Quad point containment checker
// Port-level assertions on result timing and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input qpc_pkg::rsp_type               rsp_data
);

   // Every result traces back to an item taken a fixed latency earlier.
   `QPC_ASSERT(a_latency, rsp_strobe |-> $past(start && !busy, qpc_pkg::LATENCY), "result without item")

   `QPC_ASSERT(a_degen, rsp_strobe && rsp_data.degenerate |-> !rsp_data.inside_res && rsp_data.square_u == 0 && rsp_data.square_v == 0, "degenerate result not cleared")

   `QPC_ASSERT(a_inside, rsp_strobe && rsp_data.inside_res |-> rsp_data.square_u > 0 && rsp_data.square_u < qpc_pkg::FIX_ONE && rsp_data.square_v > 0 && rsp_data.square_v < qpc_pkg::FIX_ONE, "inside flag outside unit square")

   `QPC_ASSERT_NR(a_reset, reset |=> !rsp_strobe, "result strobe after reset")

endmodule

bind quad_point_containment qpc_checker u_qpc_checker (.*);
